[rtl/time_window_sample_decimator_top_defines.svh]
// Assertion macros shared by the decimator checker.
`ifndef TIME_WINDOW_SAMPLE_DECIMATOR_TOP_DEFINES_SVH
`define TIME_WINDOW_SAMPLE_DECIMATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TWSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define TWSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/twsd_pkg.sv]
// Package of types and constants for the time window sample decimator.
`default_nettype none
package twsd_pkg;
    localparam int TIME_BITS_DEF = 48;
    localparam int PAST_LIMIT_DEF = 1000000;
    localparam logic [31:0] KAL_ONE = 32'd65536;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_POLL = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [2:0] POL_AVG = 3'd0;
    localparam logic [2:0] POL_PEAK = 3'd1;
    localparam logic [2:0] POL_LAST = 3'd2;
    localparam logic [2:0] POL_FIRST = 3'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_DUE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] REG_SEP = 3'd0;
    localparam logic [2:0] REG_POLICY = 3'd1;
    localparam logic [2:0] REG_KAL_EN = 3'd2;
    localparam logic [2:0] REG_Q = 3'd3;
    localparam logic [2:0] REG_R = 3'd4;
    localparam logic [2:0] REG_CHK = 3'd5;
    localparam logic [2:0] REG_TOL = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_AVG_DIV,
        S_REDUCE,
        S_ABSORB,
        S_KAL_DIV,
        S_KAL_MUL1,
        S_KAL_MUL2,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

[rtl/time_window_sample_decimator_top.sv]
// Top level of the time window sample decimator with a shared serial divider.
// Sequence: a request passes S_DECIDE, S_REDUCE and, for a sample, S_ABSORB before S_OUT;
// when an average closes, S_AVG_DIV first runs 64 steps of one quotient bit a cycle, and a
// sample that runs the Kalman update adds a 48-step gain divide, then S_KAL_MUL1 and S_KAL_MUL2.
// Throughput: one request at a time, since s_tready is low from acceptance until the result
// has been taken.
// Reset (aresetn low, synchronous) loads register defaults and clears window state.
`default_nettype none
module time_window_sample_decimator_top #(
    parameter int TIME_BITS = twsd_pkg::TIME_BITS_DEF,
    parameter int PAST_LIMIT_US = twsd_pkg::PAST_LIMIT_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_us [TIME_BITS-1:0], stamp_us, sample_value, zero fill
    input  wire logic [((2*TIME_BITS+32+7)/8)*8-1:0] s_tdata,
    // command
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // emit, has_value, out_value[31:0], status[1:0], stamp_error, zero fill
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);
    localparam int TB = TIME_BITS;
    // The estimate is Q32.16 whatever the time width is.
    localparam int EB = 48;

    logic [31:0] sep_reg, q_reg, r_reg, tol_reg;
    logic [2:0]  pol_reg;
    logic        kal_en_reg, chk_reg;

    logic [TB-1:0] win_start_reg;
    logic [31:0]   count_reg, peak_reg, held_reg, var_reg;
    logic [63:0]   sum_reg;
    logic [EB-1:0] est_reg;

    logic [1:0]    cmd_reg;
    logic [TB-1:0] now_reg, stamp_reg;
    logic [31:0]   val_reg;
    logic          absorb_reg;

    logic          emit_reg, has_reg, serr_reg;
    logic [1:0]    status_reg;
    logic [31:0]   outv_reg;

    // Shared restoring divider: quotient bits shift in one per cycle.
    logic [63:0] dq_reg;
    logic [49:0] drem_reg;
    logic [48:0] dden_reg;
    logic [6:0]  dcnt_reg;
    logic [50:0] dtrial;
    logic        dge;

    logic [31:0] p_reg, k_reg;
    logic [63:0] prod_reg;
    logic        mneg_reg;

    twsd_pkg::state_t state_reg, state_next;

    logic [TB-1:0] age;
    logic          due;
    logic          cnt_nz;
    logic          close;
    logic [TB-1:0] s_now, s_stamp;
    logic [31:0]   s_val;
    logic [EB-1:0] meas;
    logic [32:0]   psum;
    logic [31:0]   psat;
    logic [32:0]   den33;
    logic [EB-1:0] diff;
    logic [31:0]   avg_sat;
    logic [31:0]   kq;

    assign s_now   = s_tdata[TB-1:0];
    assign s_stamp = s_tdata[2*TB-1:TB];
    assign s_val   = s_tdata[2*TB+31:2*TB];

    assign age = now_reg - win_start_reg;
    assign due = age >= TB'(sep_reg);
    assign cnt_nz = (count_reg != 32'd0);
    // A window closes on a sample in a due window, a poll of a due nonempty window,
    // or a flush of a nonempty window.
    assign close = (cmd_reg == twsd_pkg::CMD_SAMPLE && due)
                || (cmd_reg == twsd_pkg::CMD_POLL && due && cnt_nz)
                || (cmd_reg == twsd_pkg::CMD_FLUSH && cnt_nz);
    assign meas = {val_reg, 16'd0};
    assign psum = {1'b0, var_reg} + {1'b0, q_reg};
    assign psat = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
    assign den33 = {1'b0, p_reg} + {1'b0, r_reg};
    assign diff = (meas >= est_reg) ? meas - est_reg : est_reg - meas;
    assign dtrial = {drem_reg, dq_reg[63]} - {2'd0, dden_reg};
    assign dge = !dtrial[50];
    assign avg_sat = (dq_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : dq_reg[31:0];
    // The gain quotient never exceeds 65536; a zero denominator gives zero gain.
    assign kq = (den33 == 33'd0) ? 32'd0 : dq_reg[31:0];

    assign s_tready = (state_reg == twsd_pkg::S_IDLE);
    assign m_tvalid = (state_reg == twsd_pkg::S_OUT);
    assign m_tdata  = {3'd0, serr_reg, status_reg, outv_reg, has_reg, emit_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            twsd_pkg::S_IDLE:     if (s_tvalid) state_next = twsd_pkg::S_DECIDE;
            twsd_pkg::S_DECIDE:   state_next = (close && cnt_nz && !kal_en_reg
                                                && pol_reg == twsd_pkg::POL_AVG)
                                               ? twsd_pkg::S_AVG_DIV : twsd_pkg::S_REDUCE;
            twsd_pkg::S_AVG_DIV:  if (dcnt_reg == 7'd1) state_next = twsd_pkg::S_REDUCE;
            twsd_pkg::S_REDUCE:   state_next = absorb_reg ? twsd_pkg::S_ABSORB
                                                         : twsd_pkg::S_OUT;
            twsd_pkg::S_ABSORB:   state_next = (kal_en_reg && cnt_nz) ? twsd_pkg::S_KAL_DIV
                                                                      : twsd_pkg::S_OUT;
            twsd_pkg::S_KAL_DIV:  if (dcnt_reg == 7'd1) state_next = twsd_pkg::S_KAL_MUL1;
            twsd_pkg::S_KAL_MUL1: state_next = twsd_pkg::S_KAL_MUL2;
            twsd_pkg::S_KAL_MUL2: state_next = twsd_pkg::S_OUT;
            twsd_pkg::S_OUT:      if (m_tready) state_next = twsd_pkg::S_IDLE;
            default:              state_next = twsd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= twsd_pkg::S_IDLE;
            sep_reg <= 32'd1000; pol_reg <= twsd_pkg::POL_AVG; kal_en_reg <= 1'b0;
            q_reg <= 32'd0; r_reg <= twsd_pkg::KAL_ONE; chk_reg <= 1'b0;
            tol_reg <= 32'd1000;
            win_start_reg <= '0; count_reg <= '0; sum_reg <= '0; peak_reg <= '0;
            held_reg <= '0; est_reg <= '0; var_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    twsd_pkg::REG_SEP:    sep_reg <= cfg_wdata;
                    twsd_pkg::REG_POLICY: pol_reg <= cfg_wdata[2:0];
                    twsd_pkg::REG_KAL_EN: kal_en_reg <= cfg_wdata[0];
                    twsd_pkg::REG_Q:      q_reg <= cfg_wdata;
                    twsd_pkg::REG_R:      r_reg <= cfg_wdata;
                    twsd_pkg::REG_CHK:    chk_reg <= cfg_wdata[0];
                    twsd_pkg::REG_TOL:    tol_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            state_reg <= state_next;
            case (state_reg)
                twsd_pkg::S_IDLE: begin
                    cmd_reg <= s_tuser; now_reg <= s_now; stamp_reg <= s_stamp;
                    val_reg <= s_val;
                end
                twsd_pkg::S_DECIDE: begin
                    emit_reg <= close;
                    has_reg <= close && cnt_nz;
                    outv_reg <= '0;
                    if (cmd_reg == twsd_pkg::CMD_POLL && !close)
                        status_reg <= due ? twsd_pkg::ST_EMPTY : twsd_pkg::ST_NOT_DUE;
                    else
                        status_reg <= twsd_pkg::ST_OK;
                    serr_reg <= (cmd_reg == twsd_pkg::CMD_SAMPLE) && chk_reg
                        && ((stamp_reg > now_reg && stamp_reg - now_reg > TB'(tol_reg))
                            || (now_reg > stamp_reg
                                && now_reg - stamp_reg > TB'(PAST_LIMIT_US)));
                    absorb_reg <= (cmd_reg == twsd_pkg::CMD_SAMPLE);
                    // The average divide is loaded here; it only runs when needed.
                    dq_reg <= sum_reg; drem_reg <= '0;
                    dden_reg <= {17'd0, count_reg}; dcnt_reg <= 7'd64;
                end
                twsd_pkg::S_AVG_DIV: begin
                    drem_reg <= dge ? dtrial[49:0] : {drem_reg[48:0], dq_reg[63]};
                    dq_reg <= {dq_reg[62:0], dge};
                    dcnt_reg <= dcnt_reg - 7'd1;
                end
                twsd_pkg::S_REDUCE: begin
                    if (emit_reg) begin
                        if (has_reg) begin
                            if (kal_en_reg) outv_reg <= est_reg[47:16];
                            else if (pol_reg == twsd_pkg::POL_AVG) outv_reg <= avg_sat;
                            else if (pol_reg == twsd_pkg::POL_PEAK) outv_reg <= peak_reg;
                            else outv_reg <= held_reg;
                        end
                        win_start_reg <= now_reg; count_reg <= '0;
                        sum_reg <= '0; peak_reg <= '0;
                    end
                end
                twsd_pkg::S_ABSORB: begin
                    case (pol_reg)
                        twsd_pkg::POL_AVG:
                            sum_reg <= (sum_reg > ~{32'd0, val_reg}) ? '1
                                     : sum_reg + {32'd0, val_reg};
                        twsd_pkg::POL_PEAK: if (val_reg > peak_reg) peak_reg <= val_reg;
                        twsd_pkg::POL_LAST: held_reg <= val_reg;
                        twsd_pkg::POL_FIRST: if (!cnt_nz) held_reg <= val_reg;
                        default: ;
                    endcase
                    if (count_reg != 32'hFFFF_FFFF) count_reg <= count_reg + 32'd1;
                    if (kal_en_reg) begin
                        if (!cnt_nz) begin
                            est_reg <= meas; var_reg <= twsd_pkg::KAL_ONE;
                        end else begin
                            p_reg <= psat;
                            mneg_reg <= (meas < est_reg);
                            // gain = (P << 16) / (P + R): the top 48 dividend bits are used.
                            dq_reg <= {psat, 32'd0};
                            drem_reg <= '0;
                            dden_reg <= {16'd0, 33'({1'b0, psat} + {1'b0, r_reg})};
                            dcnt_reg <= 7'd48;
                        end
                    end
                end
                twsd_pkg::S_KAL_DIV: begin
                    drem_reg <= dge ? dtrial[49:0] : {drem_reg[48:0], dq_reg[63]};
                    dq_reg <= {dq_reg[62:0], dge};
                    dcnt_reg <= dcnt_reg - 7'd1;
                end
                twsd_pkg::S_KAL_MUL1: begin
                    k_reg <= kq;
                    prod_reg <= 64'(kq[16:0]) * 64'(diff);
                end
                twsd_pkg::S_KAL_MUL2: begin
                    est_reg <= mneg_reg ? est_reg - EB'(prod_reg >> 16)
                                        : est_reg + EB'(prod_reg >> 16);
                    var_reg <= 32'((64'(twsd_pkg::KAL_ONE - k_reg) * 64'(p_reg)) >> 16);
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/twsd_checker.sv]
// Port checker for the decimator, bound to the top level.
`default_nettype none
`include "time_window_sample_decimator_top_defines.svh"
module twsd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    `TWSD_ASSERT(a_one_side, aclk, aresetn, !(s_tready && m_tvalid), "ready while result waits")
    `TWSD_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed")
    `TWSD_ASSERT(a_has_emit, aclk, aresetn, m_tvalid && m_tdata[1] |-> m_tdata[0], "value without emit")
    `TWSD_ASSERT(a_noval, aclk, aresetn, m_tvalid && !m_tdata[1] |-> m_tdata[33:2] == 32'd0, "value nonzero")
    `TWSD_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule
bind time_window_sample_decimator_top twsd_checker u_twsd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
